[hw/rtl/osm_pkg.sv]
// Shared types and constants for the order-statistic multiset unit.
`timescale 1ns / 1ps

package osm_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int IDX_W       = $clog2(CAPACITY + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [IDX_W-1:0]       USED_MAX  = IDX_W'(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_RANK   = 2'd1,
    OP_SELECT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef struct packed {
    op_t                           operation;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]        position;
  } in_req_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]        rank_count;
    logic signed [VALUE_WIDTH-1:0] selected_value;
    status_t                       status;
  } out_res_t;

  typedef struct packed {
    logic                          val_en;
    logic                          cnt_en;
    logic [ADDR_W-1:0]             addr;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]        count;
  } store_wr_t;

endpackage

[hw/rtl/order_statistic_multiset_unit.sv]
// Top level: sequencer that scans, shifts and updates the sorted multiset store.
// Sequence: op 3 and an out-of-range select answer straight from idle; else fetch and
//   compare each entry scanned, fetch once more if the scan passes the last entry, and for
//   a new value move each entry up and write it; the single store read port sets the pace.
// Throughput: one request at a time; busy drops as the result strobe is raised.
// Reset (synchronous, rst_n low) empties the store; entry memories are not cleared.
// The receiver cannot stall: out_valid is high for exactly one cycle per request.
`timescale 1ns / 1ps

module order_statistic_multiset_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  osm_pkg::in_req_t  in_req,
  output logic              out_valid,
  output osm_pkg::out_res_t out_res
);
  import osm_pkg::*;

  state_t                   state_r, state_nxt;
  in_req_t                  req_r, req_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [IDX_W-1:0]         shf_r, shf_nxt;
  logic [COUNT_WIDTH-1:0]   acc_r, acc_nxt;
  logic [IDX_W-1:0]         used_r, used_nxt;
  logic [COUNT_WIDTH-1:0]   total_r, total_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_res_t                 out_res_r, out_res_nxt;

  store_wr_t                wr;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [VALUE_WIDTH-1:0] rd_value;
  logic [COUNT_WIDTH-1:0]   rd_count;

  logic                     accept;
  logic                     scan_end;
  logic                     full;
  logic                     key_gt;
  logic                     key_eq;
  logic                     in_pos_bad;
  logic [COUNT_WIDTH:0]     acc_sum;
  logic [COUNT_WIDTH-1:0]   acc_sat;
  logic                     sel_hit;

  osm_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_count (rd_count)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // shift states read the entry below the move pointer; scans read the scan index
  assign rd_addr = (state_r == S_SHIFT_RD || state_r == S_SHIFT_WR)
                   ? ADDR_W'(shf_r - IDX_W'(1)) : idx_r[ADDR_W-1:0];

  assign scan_end   = (idx_r == used_r);
  assign full       = (used_r == USED_MAX);
  assign key_gt     = (req_r.value > rd_value);
  assign key_eq     = (req_r.value == rd_value);
  assign in_pos_bad = (in_req.position == '0) || (in_req.position > total_r);
  assign acc_sum    = {1'b0, acc_r} + {1'b0, rd_count};
  assign acc_sat    = acc_sum[COUNT_WIDTH] ? COUNT_MAX : acc_sum[COUNT_WIDTH-1:0];
  assign sel_hit    = (req_r.position <= acc_sat);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.operation == OP_NONE ||
              (in_req.operation == OP_SELECT && in_pos_bad)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (scan_end) begin
          state_nxt = (req_r.operation == OP_INSERT && !full) ? S_SHIFT_RD : S_IDLE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        case (req_r.operation)
          OP_INSERT: begin
            if (key_gt) begin
              state_nxt = S_FETCH;
            end else if (key_eq || full) begin
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SHIFT_RD;
            end
          end
          OP_RANK:   state_nxt = key_gt ? S_FETCH : S_IDLE;
          OP_SELECT: state_nxt = sel_hit ? S_IDLE : S_FETCH;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_SHIFT_RD: state_nxt = (shf_r == idx_r) ? S_IDLE : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    shf_nxt       = shf_r;
    acc_nxt       = acc_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    wr            = '0;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_req;
          idx_nxt = '0;
          acc_nxt = '0;
          if (in_req.operation == OP_NONE) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '0;
          end else if (in_req.operation == OP_SELECT && in_pos_bad) begin
            out_valid_nxt      = 1'b1;
            out_res_nxt        = '0;
            out_res_nxt.status = STAT_BAD_POS;
          end
        end
      end
      S_FETCH: begin
        if (scan_end) begin
          case (req_r.operation)
            OP_INSERT: begin
              if (full) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt        = '0;
                out_res_nxt.status = STAT_FULL;
              end else begin
                shf_nxt = used_r;
              end
            end
            OP_RANK: begin
              out_valid_nxt          = 1'b1;
              out_res_nxt            = '0;
              out_res_nxt.rank_count = acc_r;
            end
            default: begin
              out_valid_nxt      = 1'b1;
              out_res_nxt        = '0;
              out_res_nxt.status = STAT_BAD_POS;
            end
          endcase
        end
      end
      S_CMP: begin
        case (req_r.operation)
          OP_INSERT: begin
            if (key_gt) begin
              idx_nxt = idx_r + IDX_W'(1);
            end else if (key_eq) begin
              // bump an existing entry unless a count would saturate
              if (rd_count != COUNT_MAX && total_r != COUNT_MAX) begin
                wr.cnt_en = 1'b1;
                wr.addr   = idx_r[ADDR_W-1:0];
                wr.count  = rd_count + COUNT_WIDTH'(1);
                total_nxt = total_r + COUNT_WIDTH'(1);
              end
              out_valid_nxt = 1'b1;
              out_res_nxt   = '0;
            end else if (full) begin
              out_valid_nxt      = 1'b1;
              out_res_nxt        = '0;
              out_res_nxt.status = STAT_FULL;
            end else begin
              shf_nxt = used_r;
            end
          end
          OP_RANK: begin
            if (key_gt) begin
              acc_nxt = acc_sat;
              idx_nxt = idx_r + IDX_W'(1);
            end else begin
              out_valid_nxt          = 1'b1;
              out_res_nxt            = '0;
              out_res_nxt.rank_count = acc_r;
            end
          end
          OP_SELECT: begin
            if (sel_hit) begin
              out_valid_nxt              = 1'b1;
              out_res_nxt                = '0;
              out_res_nxt.selected_value = rd_value;
            end else begin
              acc_nxt = acc_sat;
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '0;
          end
        endcase
      end
      S_SHIFT_RD: begin
        // gap has reached the insertion point: drop the new value in
        if (shf_r == idx_r) begin
          wr.val_en     = 1'b1;
          wr.cnt_en     = 1'b1;
          wr.addr       = idx_r[ADDR_W-1:0];
          wr.value      = req_r.value;
          wr.count      = COUNT_WIDTH'(1);
          used_nxt      = used_r + IDX_W'(1);
          if (total_r != COUNT_MAX) begin
            total_nxt = total_r + COUNT_WIDTH'(1);
          end
          out_valid_nxt = 1'b1;
          out_res_nxt   = '0;
        end
      end
      S_SHIFT_WR: begin
        // move the entry below the gap up by one
        wr.val_en = 1'b1;
        wr.cnt_en = 1'b1;
        wr.addr   = shf_r[ADDR_W-1:0];
        wr.value  = rd_value;
        wr.count  = rd_count;
        shf_nxt   = shf_r - IDX_W'(1);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    shf_r     <= shf_nxt;
    acc_r     <= acc_nxt;
    out_res_r <= out_res_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_MAX)
    else $error("distinct entry count beyond capacity");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r))
    else $error("element total decreased");

  a_shift_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_RD || state_r == S_SHIFT_WR) |-> !full)
    else $error("shift started on a full store");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid_r |-> $past(start) || $past(state_r != S_IDLE))
    else $error("result strobe without a request in flight");

  a_shift_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT_WR |-> shf_r > idx_r)
    else $error("shift pointer passed the insertion point");

endmodule

[hw/rtl/osm_store.sv]
// Sorted entry store: value and count memories, one write and one registered read.
`timescale 1ns / 1ps

module osm_store (
  input  logic                                    clk,
  input  osm_pkg::store_wr_t                      wr,
  input  logic [osm_pkg::ADDR_W-1:0]              rd_addr,
  output logic signed [osm_pkg::VALUE_WIDTH-1:0]  rd_value,
  output logic [osm_pkg::COUNT_WIDTH-1:0]         rd_count
);
  import osm_pkg::*;

  logic signed [VALUE_WIDTH-1:0] value_mem [CAPACITY];
  logic [COUNT_WIDTH-1:0]        count_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.val_en) begin
      value_mem[wr.addr] <= wr.value;
    end
    if (wr.cnt_en) begin
      count_mem[wr.addr] <= wr.count;
    end
    rd_value <= value_mem[rd_addr];
    rd_count <= count_mem[rd_addr];
  end

endmodule
